FILE: hdl/cfpa_pkg.sv
`default_nettype none

package cfpa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int DW = 3 * W + F + 2;
    localparam int TW = 2 * W + 2;
    localparam int PB = $clog2(W);

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_MIN = 3'd4,
        ACT_MAG = 3'd5
    } action_t;

    typedef struct packed {
        logic                valid;
        logic [2:0]          act;
        logic [W-1:0]        d_re;
        logic [W-1:0]        d_im;
        logic                d_dz;
        logic                d_ovf;
        logic                neg_re;
        logic                neg_im;
        logic                over_re;
        logic                over_im;
        logic [DW-1:0]       den;
        logic [DW-1:0]       rem_re;
        logic [DW-1:0]       rem_im;
        logic [W-1:0]        q_re;
        logic [W-1:0]        q_im;
        logic [TW-1:0]       srem;
        logic [W-1:0]        root;
    } pipe_t;

    function automatic logic signed [SW-1:0] sat_max();
        sat_max = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    endfunction

    // saturate to the word range; msb of the result is the overflow flag
    function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] mx;
        logic signed [SW-1:0] mn;
        mx = sat_max();
        mn = ~mx;
        if (v > mx)
            sat_fn = {1'b1, mx[W-1:0]};
        else if (v < mn)
            sat_fn = {1'b1, mn[W-1:0]};
        else
            sat_fn = {1'b0, v[W-1:0]};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cfpa_cell.sv
`default_nettype none

module cfpa_cell
    import cfpa_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic [PB-1:0] pos,
    input  wire pipe_t         din,
    output pipe_t              dout
);

    pipe_t dout_reg;
    pipe_t dout_next;

    always_comb
    begin
        logic [DW-1:0] sub;
        logic [TW-1:0] trial;
        int            sh;
        sh        = int'(pos);
        dout_next = din;
        sub       = din.den << sh;
        if (din.rem_re >= sub)
        begin
            dout_next.rem_re = din.rem_re - sub;
            dout_next.q_re   = din.q_re | (W'(1) << sh);
        end
        if (din.rem_im >= sub)
        begin
            dout_next.rem_im = din.rem_im - sub;
            dout_next.q_im   = din.q_im | (W'(1) << sh);
        end
        trial = (TW'(din.root) << (sh + 1)) | (TW'(1) << (2 * sh));
        if (din.srem >= trial)
        begin
            dout_next.srem = din.srem - trial;
            dout_next.root = din.root | (W'(1) << sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

FILE: hdl/cfpa_front.sv
`default_nettype none

module cfpa_front
    import cfpa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         adv,
    input  wire logic         in_valid,
    input  wire logic [2:0]   action,
    input  wire logic [W-1:0] a_re,
    input  wire logic [W-1:0] a_im,
    input  wire logic [W-1:0] b_re,
    input  wire logic [W-1:0] b_im,
    output pipe_t             dout
);

    logic                 va_reg;
    logic [2:0]           act_a_reg;
    logic signed [W-1:0]  ar_a_reg, ai_a_reg, br_a_reg, bi_a_reg;

    logic                 vb_reg;
    logic [2:0]           act_b_reg;
    logic signed [W-1:0]  ar_b_reg, ai_b_reg, br_b_reg, bi_b_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW-1:0] sa_r_reg, sa_i_reg, sb_r_reg, sb_i_reg;

    logic                 vc_reg;
    logic [2:0]           act_c_reg;
    logic [W-1:0]         dre_c_reg, dim_c_reg;
    logic                 dz_c_reg, ovf_c_reg;
    logic signed [SW-1:0] nre_c_reg, nim_c_reg;
    logic [DW-1:0]        den_c_reg;
    logic [TW-1:0]        maga_c_reg;

    logic [W-1:0]         dre_next, dim_next;
    logic                 dz_next, ovf_next;
    logic signed [SW-1:0] nre_next, nim_next;
    logic [DW-1:0]        den_next;
    logic [TW-1:0]        maga_next;

    pipe_t                dout_reg;
    pipe_t                dout_next;

    function automatic logic signed [SW-1:0] ext_p(input logic signed [PW-1:0] p);
        ext_p = {{(SW-PW){p[PW-1]}}, p};
    endfunction

    function automatic logic signed [SW-1:0] ext_w(input logic signed [W-1:0] p);
        ext_w = {{(SW-W){p[W-1]}}, p};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act_a_reg  <= action;
            ar_a_reg   <= a_re;
            ai_a_reg   <= a_im;
            br_a_reg   <= b_re;
            bi_a_reg   <= b_im;

            act_b_reg  <= act_a_reg;
            ar_b_reg   <= ar_a_reg;
            ai_b_reg   <= ai_a_reg;
            br_b_reg   <= br_a_reg;
            bi_b_reg   <= bi_a_reg;
            p_rr_reg   <= ar_a_reg * br_a_reg;
            p_ii_reg   <= ai_a_reg * bi_a_reg;
            p_ri_reg   <= ar_a_reg * bi_a_reg;
            p_ir_reg   <= ai_a_reg * br_a_reg;
            sa_r_reg   <= ar_a_reg * ar_a_reg;
            sa_i_reg   <= ai_a_reg * ai_a_reg;
            sb_r_reg   <= br_a_reg * br_a_reg;
            sb_i_reg   <= bi_a_reg * bi_a_reg;

            act_c_reg  <= act_b_reg;
            dre_c_reg  <= dre_next;
            dim_c_reg  <= dim_next;
            dz_c_reg   <= dz_next;
            ovf_c_reg  <= ovf_next;
            nre_c_reg  <= nre_next;
            nim_c_reg  <= nim_next;
            den_c_reg  <= den_next;
            maga_c_reg <= maga_next;
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] s_re;
        logic signed [SW-1:0] s_im;
        logic [W:0]           r_re;
        logic [W:0]           r_im;
        logic [TW-1:0]        magb;
        s_re      = '0;
        s_im      = '0;
        nre_next  = ext_p(p_rr_reg) + ext_p(p_ii_reg);
        nim_next  = ext_p(p_ir_reg) - ext_p(p_ri_reg);
        den_next  = DW'(PW'(sb_r_reg)) + DW'(PW'(sb_i_reg));
        maga_next = TW'(PW'(sa_r_reg)) + TW'(PW'(sa_i_reg));
        magb      = TW'(PW'(sb_r_reg)) + TW'(PW'(sb_i_reg));
        dz_next   = 1'b0;
        case (act_b_reg)
            ACT_ADD:
            begin
                s_re = ext_w(ar_b_reg) + ext_w(br_b_reg);
                s_im = ext_w(ai_b_reg) + ext_w(bi_b_reg);
            end
            ACT_SUB:
            begin
                s_re = ext_w(ar_b_reg) - ext_w(br_b_reg);
                s_im = ext_w(ai_b_reg) - ext_w(bi_b_reg);
            end
            ACT_MUL:
            begin
                s_re = (ext_p(p_rr_reg) - ext_p(p_ii_reg)) >>> F;
                s_im = (ext_p(p_ri_reg) + ext_p(p_ir_reg)) >>> F;
            end
            ACT_DIV:
            begin
                dz_next = (br_b_reg == '0) && (bi_b_reg == '0);
            end
            ACT_MIN:
            begin
                if (maga_next <= magb)
                begin
                    s_re = ext_w(ar_b_reg);
                    s_im = ext_w(ai_b_reg);
                end
                else
                begin
                    s_re = ext_w(br_b_reg);
                    s_im = ext_w(bi_b_reg);
                end
            end
            default:
            begin
                s_re = '0;
            end
        endcase
        r_re     = sat_fn(s_re);
        r_im     = sat_fn(s_im);
        dre_next = r_re[W-1:0];
        dim_next = r_im[W-1:0];
        ovf_next = r_re[W] | r_im[W];
    end

    always_comb
    begin
        logic [SW-1:0] abs_re;
        logic [SW-1:0] abs_im;
        logic [DW-1:0] lim;
        abs_re            = nre_c_reg[SW-1] ? SW'(-nre_c_reg) : SW'(nre_c_reg);
        abs_im            = nim_c_reg[SW-1] ? SW'(-nim_c_reg) : SW'(nim_c_reg);
        lim               = den_c_reg << W;
        dout_next         = '0;
        dout_next.valid   = vc_reg;
        dout_next.act     = act_c_reg;
        dout_next.d_re    = dre_c_reg;
        dout_next.d_im    = dim_c_reg;
        dout_next.d_dz    = dz_c_reg;
        dout_next.d_ovf   = ovf_c_reg;
        dout_next.neg_re  = nre_c_reg[SW-1];
        dout_next.neg_im  = nim_c_reg[SW-1];
        dout_next.den     = den_c_reg;
        dout_next.rem_re  = DW'(abs_re) << F;
        dout_next.rem_im  = DW'(abs_im) << F;
        dout_next.over_re = dout_next.rem_re >= lim;
        dout_next.over_im = dout_next.rem_im >= lim;
        dout_next.srem    = maga_c_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

`default_nettype wire

FILE: hdl/complex_fixed_point_alu.sv
// Complex fixed-point ALU, signed Q16.16 operands and results.
// Input channel: in_valid / in_stall with action, a_re, a_im, b_re, b_im.
// Output channel: out_valid / out_stall with res_re, res_im, div_zero,
// overflow. A transfer happens on a rising edge with valid high, stall low.
// Pipeline: four front stages (register, products, sums, divide setup),
// then one cell per result bit, 32 cells, then one output stage.
// Throughput: one item per cycle while the output is not stalled. Each cell of the
// chain resolves one quotient bit of both divider lanes and one root bit per cycle.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped.
// Reset clears all valid bits; the block can take a transfer as soon as
// reset is released.
`default_nettype none

module complex_fixed_point_alu
    import cfpa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [2:0]   action,
    input  wire logic [W-1:0] a_re,
    input  wire logic [W-1:0] a_im,
    input  wire logic [W-1:0] b_re,
    input  wire logic [W-1:0] b_im,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [W-1:0]      res_re,
    output logic [W-1:0]      res_im,
    output logic              div_zero,
    output logic              overflow
);

    pipe_t        chain [W+1];
    pipe_t        last;
    logic         adv;

    logic         out_valid_reg;
    logic [W-1:0] res_re_reg, res_re_next;
    logic [W-1:0] res_im_reg, res_im_next;
    logic         dz_reg, dz_next;
    logic         ovf_reg, ovf_next;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    cfpa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .action   (action),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .dout     (chain[0])
    );

    for (genvar k = 0; k < W; k++)
    begin : g_cell
        cfpa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .pos   (PB'(W - 1 - k)),
            .din   (chain[k]),
            .dout  (chain[k+1])
        );
    end

    assign last = chain[W];

    function automatic logic [W:0] div_part(input logic neg, input logic over,
                                            input logic [W-1:0] q);
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] mx;
        mx = sat_max();
        if (over)
            div_part = neg ? {1'b1, ~mx[W-1:0]} : {1'b1, mx[W-1:0]};
        else
        begin
            v        = neg ? -$signed(SW'(q)) : $signed(SW'(q));
            div_part = sat_fn(v);
        end
    endfunction

    always_comb
    begin
        logic [W:0] r_re;
        logic [W:0] r_im;
        res_re_next = last.d_re;
        res_im_next = last.d_im;
        dz_next     = last.d_dz;
        ovf_next    = last.d_ovf;
        r_re        = div_part(last.neg_re, last.over_re, last.q_re);
        r_im        = div_part(last.neg_im, last.over_im, last.q_im);
        case (last.act)
            ACT_DIV:
            begin
                if (!last.d_dz)
                begin
                    res_re_next = r_re[W-1:0];
                    res_im_next = r_im[W-1:0];
                    ovf_next    = r_re[W] | r_im[W];
                end
                else
                begin
                    res_re_next = '0;
                    res_im_next = '0;
                    ovf_next    = 1'b0;
                end
            end
            ACT_MAG:
            begin
                res_im_next = '0;
                ovf_next    = last.root[W-1];
                res_re_next = last.root[W-1] ? {1'b0, {(W-1){1'b1}}} : last.root;
            end
            default:
            begin
                res_re_next = last.d_re;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            dz_reg     <= dz_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign div_zero  = dz_reg;
    assign overflow  = ovf_reg;

`ifndef ASSERT_OFF
    a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(div_zero && overflow))
        else $error("div_zero with overflow");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_zero) |-> (res_re == '0 && res_im == '0))
        else $error("div_zero result not zero");

    a_mag_im: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && last.valid && last.act == ACT_MAG) |=> (out_valid && res_im == '0))
        else $error("magnitude imaginary part not zero");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |->
            (res_re == {1'b0, {(W-1){1'b1}}} || res_re == {1'b1, {(W-1){1'b0}}} ||
             res_im == {1'b0, {(W-1){1'b1}}} || res_im == {1'b1, {(W-1){1'b0}}}))
        else $error("overflow without saturated part");
`endif

endmodule

`default_nettype wire

FILE: tb/cfpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cfpa_checker
    import cfpa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_stall,
    input  wire logic [2:0]   action,
    input  wire logic [W-1:0] a_re,
    input  wire logic [W-1:0] a_im,
    input  wire logic [W-1:0] b_re,
    input  wire logic [W-1:0] b_im,
    input  wire logic         out_valid,
    input  wire logic         out_stall,
    input  wire logic [W-1:0] res_re,
    input  wire logic [W-1:0] res_im,
    input  wire logic         div_zero,
    input  wire logic         overflow,
    output int                errors,
    output int                pending
);

    typedef struct {
        logic [W-1:0] re;
        logic [W-1:0] im;
        logic         dz;
        logic         ovf;
    } cplx_result_t;

    cplx_result_t expected_results[$];

    function automatic logic [W-1:0] clamp_word(input logic signed [159:0] v,
                                                inout logic ovf);
        logic signed [159:0] top_val;
        logic signed [159:0] bot_val;
        top_val = (160'sd1 <<< (W - 1)) - 160'sd1;
        bot_val = -top_val - 160'sd1;
        if (v > top_val)
        begin
            ovf = 1'b1;
            return top_val[W-1:0];
        end
        if (v < bot_val)
        begin
            ovf = 1'b1;
            return bot_val[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic cplx_result_t compute_result(input logic [2:0] op,
        input logic [W-1:0] ar, input logic [W-1:0] ai,
        input logic [W-1:0] br, input logic [W-1:0] bi);
        cplx_result_t r;
        logic signed [159:0] xr, xi, yr, yi, den, num_re, num_im, sq_a, sq_b;
        logic [127:0] msq, root, t;
        xr = $signed(ar);
        xi = $signed(ai);
        yr = $signed(br);
        yi = $signed(bi);
        r.re = '0;
        r.im = '0;
        r.dz = 1'b0;
        r.ovf = 1'b0;
        case (op)
            ACT_ADD:
            begin
                r.re = clamp_word(xr + yr, r.ovf);
                r.im = clamp_word(xi + yi, r.ovf);
            end
            ACT_SUB:
            begin
                r.re = clamp_word(xr - yr, r.ovf);
                r.im = clamp_word(xi - yi, r.ovf);
            end
            ACT_MUL:
            begin
                r.re = clamp_word((xr * yr - xi * yi) >>> F, r.ovf);
                r.im = clamp_word((xr * yi + xi * yr) >>> F, r.ovf);
            end
            ACT_DIV:
            begin
                if (yr == 0 && yi == 0)
                    r.dz = 1'b1;
                else
                begin
                    den = yr * yr + yi * yi;
                    num_re = (xr * yr + xi * yi) <<< F;
                    num_im = (xi * yr - xr * yi) <<< F;
                    r.re = clamp_word(num_re / den, r.ovf);
                    r.im = clamp_word(num_im / den, r.ovf);
                end
            end
            ACT_MIN:
            begin
                sq_a = xr * xr + xi * xi;
                sq_b = yr * yr + yi * yi;
                if (sq_a <= sq_b)
                begin
                    r.re = ar;
                    r.im = ai;
                end
                else
                begin
                    r.re = br;
                    r.im = bi;
                end
            end
            ACT_MAG:
            begin
                sq_a = xr * xr + xi * xi;
                msq = sq_a[127:0];
                root = '0;
                for (int b = 62; b >= 0; b--)
                begin
                    t = root | (128'd1 << b);
                    if (t * t <= msq)
                        root = t;
                end
                if (root > (128'd1 << (W - 1)) - 128'd1)
                begin
                    root = (128'd1 << (W - 1)) - 128'd1;
                    r.ovf = 1'b1;
                end
                r.re = root[W-1:0];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30)
            $display("cfpa_checker: %0t: %s", $realtime, msg);
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        cplx_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(compute_result(action, a_re, a_im, b_re, b_im));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    if (res_re !== want.re)
                        report_mismatch($sformatf("res_re %h, want %h", res_re, want.re));
                    if (res_im !== want.im)
                        report_mismatch($sformatf("res_im %h, want %h", res_im, want.im));
                    if (div_zero !== want.dz)
                        report_mismatch($sformatf("div_zero %b, want %b", div_zero, want.dz));
                    if (overflow !== want.ovf)
                        report_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_top
    import cfpa_pkg::*;
();

    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;
    localparam logic [W-1:0] WMAX = 32'h7fff_ffff;
    localparam logic [W-1:0] WMIN = 32'h8000_0000;
    localparam logic [W-1:0] ONE = 32'h0001_0000;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT = 200000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         in_stall;
    logic [2:0]   action = '0;
    logic [W-1:0] a_re = '0;
    logic [W-1:0] a_im = '0;
    logic [W-1:0] b_re = '0;
    logic [W-1:0] b_im = '0;
    logic         out_valid;
    logic         out_stall = 1'b0;
    logic [W-1:0] res_re;
    logic [W-1:0] res_im;
    logic         div_zero;
    logic         overflow;
    int           errors;
    int           pending;
    logic         idling_on = 1'b1;
    logic         hold_request = 1'b0;
    int           cycles = 0;

    complex_fixed_point_alu u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_re(res_re), .res_im(res_im), .div_zero(div_zero), .overflow(overflow)
    );

    cfpa_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_re(res_re), .res_im(res_im), .div_zero(div_zero), .overflow(overflow),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off to fill the pipeline
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idling_on && ($urandom_range(99) < 21);
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [W-1:0] ar,
        input logic [W-1:0] ai, input logic [W-1:0] br, input logic [W-1:0] bi);
        while (idling_on && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= op;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [W-1:0] pick_part();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? WMAX : WMIN;
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            3: return 32'($signed($urandom_range(0, 512)) - 256);
            4: return $urandom_range(0, 1) ? 32'(ONE * $urandom_range(1, 3)) : '0;
            default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    function automatic logic [2:0] pick_op();
        if ($urandom_range(99) < 4)
            return $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
        return 3'($urandom_range(ACT_ADD, ACT_MAG));
    endfunction

    initial
    begin
        logic [W-1:0] br, bi;
        logic [2:0] op;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ACT_ADD, WMAX, WMIN, WMAX, WMIN);
        send_item(ACT_ADD, ONE, 32'hffff_0000, 32'h0000_8000, 32'd1);
        send_item(ACT_SUB, WMIN, WMAX, WMAX, WMIN);
        send_item(ACT_SUB, '0, '0, WMIN, 32'd5);
        send_item(ACT_MUL, WMAX, WMAX, WMAX, WMIN);
        send_item(ACT_MUL, WMIN, WMIN, WMIN, WMIN);
        send_item(ACT_MUL, 32'hffff_ffff, '0, 32'd1, '0);
        send_item(ACT_MUL, ONE, ONE, 32'h0002_0000, 32'hfffe_0000);
        send_item(ACT_DIV, ONE, ONE, '0, '0);
        send_item(ACT_DIV, WMIN, WMIN, '0, '0);
        send_item(ACT_DIV, WMAX, WMIN, 32'd1, '0);
        send_item(ACT_DIV, 32'hffff_ffff, 32'd3, ONE, ONE);
        send_item(ACT_DIV, WMIN, WMIN, WMIN, WMIN);
        send_item(ACT_DIV, 32'h0003_0000, 32'hfffc_0000, '0, 32'd1);
        send_item(ACT_MIN, ONE, '0, '0, ONE);
        send_item(ACT_MIN, WMAX, WMAX, WMIN, 32'd7);
        send_item(ACT_MIN, WMIN, WMIN, WMAX, WMAX);
        send_item(ACT_MIN, 32'h0003_0000, 32'h0004_0000, 32'hfffb_0000, '0);
        send_item(ACT_MAG, WMAX, WMAX, '0, '0);
        send_item(ACT_MAG, WMIN, WMIN, '0, '0);
        send_item(ACT_MAG, WMIN, '0, '0, '0);
        send_item(ACT_MAG, '0, '0, WMAX, WMAX);
        send_item(ACT_MAG, 32'h0003_0000, 32'hfffc_0000, '0, '0);
        send_item(ACT_SPARE6, WMAX, WMIN, ONE, ONE);
        send_item(ACT_SPARE7, 32'hffff_ffff, 32'hffff_ffff, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idling_on <= !(n >= 150 && n < 250);
            hold_request <= (n == 60);
            op = pick_op();
            br = pick_part();
            bi = pick_part();
            if (op == ACT_DIV && $urandom_range(9) == 0)
            begin
                br = '0;
                bi = '0;
            end
            send_item(op, pick_part(), pick_part(), br, bi);
        end
        in_valid <= 1'b0;
        hold_request <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: complex_fixed_point_alu.f
hdl/cfpa_pkg.sv
hdl/cfpa_cell.sv
hdl/cfpa_front.sv
hdl/complex_fixed_point_alu.sv
tb/cfpa_checker.sv
tb/tb_top.sv
